### design/gli_pkg.sv
// ============================================================================
// gli_pkg
// Types and constants shared by the linking integral engine and its checker.
// ============================================================================
package gli_pkg;

   localparam int NORM_BITS    = 20;
   localparam int ACC_FRAC     = 24;
   localparam int RESULT_SHIFT = 8;
   localparam int CSR_AW       = 4;
   localparam logic [31:0] INV_4PI_Q32 = 32'd341782638;

   typedef enum logic [1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MODE    = 2'd0,
      REG_COUNT_A = 2'd1,
      REG_COUNT_B = 2'd2
   } reg_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PAIR, S_READ, S_SETUP, S_NORM, S_MUL, S_SQRT, S_DEN,
      S_DIVI, S_DIVF, S_ACC, S_NEXT, S_FIN0, S_FIN1, S_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         index;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } req_type;

   typedef struct packed {
      logic signed [31:0] link_value;
      logic               overflow;
   } rsp_type;

   // Element 0 is x, 1 is y, 2 is z.
   typedef logic [2:0][31:0] point_type;

endpackage

### design/gauss_linking_integral.sv
// ============================================================================
// gauss_linking_integral
// Discrete Gauss linking integral and writhe of closed polygonal curves.
// ============================================================================
// Channel   Ports                          Moves
// input     req_valid/req_ready/req_data   point write or compute command
// result    rsp_valid/rsp_ready/rsp_data   link value and overflow flag
// config    psel/penable/pwrite/paddr/...  mode, count_a, count_b
//
// A point write leaves the block in its idle state, so it stays ready.
// A compute visits every point pair, using the shared multiplier, the
// bit-serial square root (22 steps) and the bit-serial divider (6 plus up to
// 84 steps) per pair, and ends with the scaling states FIN0, FIN1 and OUT.
// A pair with zero distance or zero tangent is skipped before the multiplies.
// Reset is synchronous and clears control state; the point stores are not
// cleared. A result waiting on rsp_ready holds only the final scaling stage.
// ============================================================================
module gauss_linking_integral #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  gli_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gli_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [gli_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import gli_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam logic [31:0] MAXP = 32'(MAX_POINTS);

   function automatic logic [31:0] mag33(logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      mag33 = v[32] ? n[31:0] : v[31:0];
   endfunction

   function automatic logic signed [21:0] snorm(logic s, logic [19:0] m);
      logic signed [21:0] p;
      p = $signed({2'b00, m});
      snorm = s ? -p : p;
   endfunction

   // Configuration.
   logic        mode_ff;
   logic [10:0] count_a_ff, count_b_ff;

   // Control.
   state_type   state_ff, state_in;
   logic [6:0]  step_ff, step_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] na_ff, na_in, nj_ff, nj_in;
   logic        other_b_ff, other_b_in;
   logic        ovf_ff, ovf_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Datapath.
   point_type   pa_ff, pa_in, pb_ff, pb_in, nx_ff, nx_in;
   logic signed [32:0] ta_ff [3], ta_in [3], tb_ff [3], tb_in [3];
   logic [31:0] nmag_ff [3][3], nmag_in [3][3];
   logic [2:0]  nsgn_ff [3], nsgn_in [3];
   logic signed [5:0] nsh_ff [3], nsh_in [3];
   logic signed [41:0] c_ff [3], c_in [3];
   logic signed [63:0] num_ff, num_in;
   logic [42:0] sq_ff, sq_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [42:0] sx_ff, sx_in, sr_ff, sr_in, sbit_ff, sbit_in;
   logic signed [7:0] t_ff, t_in;
   logic        nneg_ff, nneg_in;
   logic [62:0] den_ff, den_in;
   logic [67:0] dv_ff, dv_in;
   logic [63:0] rem_ff, rem_in, q_ff, q_in;
   logic signed [63:0] sum_ff, sum_in;
   logic [63:0] fprod_ff, fprod_in;
   logic [31:0] facc_ff, facc_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // Helpers.
   logic        wr_a_en, wr_b_en, idx_ok;
   logic [AW-1:0] wr_addr, rd_addr;
   point_type   wr_pt, rd_a, rd_b, rd_pt;
   logic [CW-1:0] cnt_a_cl, cnt_b_cl;
   logic [AW-1:0] i_nxt, i_prv, j_nxt, j_prv;
   logic        i_last, j_last;
   logic signed [32:0] e_v [3];
   logic        e_zero, ta_zero, tb_zero;
   logic [31:0] n_or [3];
   logic [2:0]  n_hi, n_lo;
   logic signed [21:0] nv [3][3];
   logic signed [42:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [64:0] mul_full;
   logic [31:0] fmul_a;
   logic [63:0] ps_mag, num_mag, tm, res_full;
   logic signed [63:0] term, sum_raw;
   logic [7:0]  nsh8;
   logic [20:0] d_root;
   logic [67:0] rem_ext;
   logic [64:0] rem2;
   logic        ge;
   logic [42:0] sq_tmp;
   logic [31:0] res_val;
   logic        res_sat, out_load;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         count_a_ff <= 11'd1;
         count_b_ff <= 11'd1;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_MODE:    mode_ff    <= pwdata[0];
            REG_COUNT_A: count_a_ff <= pwdata[10:0];
            REG_COUNT_B: count_b_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MODE:    prdata = {31'd0, mode_ff};
         REG_COUNT_A: prdata = {21'd0, count_a_ff};
         REG_COUNT_B: prdata = {21'd0, count_b_ff};
         default:     prdata = 32'd0;
      endcase
   end

   // Point stores.
   assign idx_ok  = (32'(req_data.index) < MAXP);
   assign wr_addr = AW'(req_data.index);
   assign wr_pt   = {req_data.pz, req_data.py, req_data.px};

   gli_curve_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem_a (
      .clock(clock), .wr_en(wr_a_en), .wr_addr(wr_addr), .wr_data(wr_pt),
      .rd_addr(rd_addr), .rd_data(rd_a)
   );

   gli_curve_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem_b (
      .clock(clock), .wr_en(wr_b_en), .wr_addr(wr_addr), .wr_data(wr_pt),
      .rd_addr(rd_addr), .rd_data(rd_b)
   );

   // Shared multipliers.
   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[63:0];
   assign fprod_in = 64'(fmul_a) * 64'(INV_4PI_Q32);

   always_comb begin
      cnt_a_cl = (32'(count_a_ff) > MAXP) ? CW'(MAXP) : CW'(count_a_ff);
      cnt_b_cl = (32'(count_b_ff) > MAXP) ? CW'(MAXP) : CW'(count_b_ff);
      i_last = (32'(i_ff) + 32'd1 == 32'(na_ff));
      j_last = (32'(j_ff) + 32'd1 == 32'(nj_ff));
      i_nxt = i_last ? '0 : i_ff + 1'b1;
      j_nxt = j_last ? '0 : j_ff + 1'b1;
      i_prv = (i_ff == '0) ? AW'(na_ff - 1'b1) : i_ff - 1'b1;
      j_prv = (j_ff == '0) ? AW'(nj_ff - 1'b1) : j_ff - 1'b1;
      rd_pt = (step_ff <= 7'd3) ? rd_a : (other_b_ff ? rd_b : rd_a);
      for (int k = 0; k < 3; k++) begin
         e_v[k] = 33'($signed(pa_ff[k])) - 33'($signed(pb_ff[k]));
      end
      e_zero  = (e_v[0] == '0) && (e_v[1] == '0) && (e_v[2] == '0);
      ta_zero = (ta_ff[0] == '0) && (ta_ff[1] == '0) && (ta_ff[2] == '0);
      tb_zero = (tb_ff[0] == '0) && (tb_ff[1] == '0) && (tb_ff[2] == '0);
      for (int v = 0; v < 3; v++) begin
         n_or[v] = nmag_ff[v][0] | nmag_ff[v][1] | nmag_ff[v][2];
         n_hi[v] = |n_or[v][31:NORM_BITS];
         n_lo[v] = ~n_or[v][NORM_BITS-1];
         for (int k = 0; k < 3; k++) begin
            nv[v][k] = snorm(nsgn_ff[v][k], nmag_ff[v][k][NORM_BITS-1:0]);
         end
      end
      d_root  = sr_ff[20:0];
      sq_tmp  = sr_ff + sbit_ff;
      rem_ext = {4'd0, rem_ff};
      rem2    = {rem_ff, 1'b0};
      num_mag = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
      ps_mag  = sum_ff[63] ? 64'(-sum_ff) : 64'(sum_ff);
      nsh8    = 8'(-t_ff);
      if (t_ff[7]) begin
         tm = (nsh8 >= 8'd7) ? 64'd0 : 64'(q_ff[5:0] >> nsh8[2:0]);
      end else begin
         tm = q_ff;
      end
      term    = nneg_ff ? -$signed(tm) : $signed(tm);
      sum_raw = sum_ff + term;
      res_full = (fprod_ff + 64'(facc_ff)) >> RESULT_SHIFT;
      if (sum_ff[63]) begin
         res_sat = (res_full > 64'h8000_0000);
         res_val = res_sat ? 32'h8000_0000 : 32'(-res_full);
      end else begin
         res_sat = (res_full > 64'h7FFF_FFFF);
         res_val = res_sat ? 32'h7FFF_FFFF : res_full[31:0];
      end
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in = state_ff; step_in = step_ff;
      i_in = i_ff; j_in = j_ff; na_in = na_ff; nj_in = nj_ff;
      other_b_in = other_b_ff; ovf_in = ovf_ff;
      pa_in = pa_ff; pb_in = pb_ff; nx_in = nx_ff;
      ta_in = ta_ff; tb_in = tb_ff;
      nmag_in = nmag_ff; nsgn_in = nsgn_ff; nsh_in = nsh_ff;
      c_in = c_ff; num_in = num_ff; sq_in = sq_ff;
      sx_in = sx_ff; sr_in = sr_ff; sbit_in = sbit_ff;
      t_in = t_ff; nneg_in = nneg_ff; den_in = den_ff; dv_in = dv_ff;
      rem_in = rem_ff; q_in = q_ff; sum_in = sum_ff;
      facc_in = facc_ff; rsp_data_in = rsp_data_ff;
      wr_a_en = 1'b0; wr_b_en = 1'b0; rd_addr = '0;
      mul_a = '0; mul_b = '0; fmul_a = '0;
      ge = 1'b0; out_load = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.command)
                  CMD_WRITE_A: wr_a_en = idx_ok;
                  CMD_WRITE_B: wr_b_en = idx_ok;
                  CMD_COMPUTE: begin
                     na_in      = cnt_a_cl;
                     nj_in      = mode_ff ? cnt_a_cl : cnt_b_cl;
                     other_b_in = !mode_ff;
                     sum_in     = '0;
                     ovf_in     = 1'b0;
                     i_in       = '0;
                     j_in       = '0;
                     if (cnt_a_cl == '0 || (mode_ff ? cnt_a_cl : cnt_b_cl) == '0) begin
                        state_in = S_FIN0;
                     end else begin
                        state_in = S_PAIR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PAIR: begin
            step_in = '0;
            state_in = (mode_ff && i_ff == j_ff) ? S_NEXT : S_READ;
         end
         S_READ: begin
            case (step_ff[2:0])
               3'd0: rd_addr = i_ff;
               3'd1: rd_addr = i_nxt;
               3'd2: rd_addr = i_prv;
               3'd3: rd_addr = j_ff;
               3'd4: rd_addr = j_nxt;
               3'd5: rd_addr = j_prv;
               default: rd_addr = '0;
            endcase
            case (step_ff[2:0])
               3'd1: pa_in = rd_pt;
               3'd2: nx_in = rd_pt;
               3'd3: begin
                  for (int k = 0; k < 3; k++) begin
                     ta_in[k] = 33'($signed(nx_ff[k])) - 33'($signed(rd_pt[k]));
                  end
               end
               3'd4: pb_in = rd_pt;
               3'd5: nx_in = rd_pt;
               3'd6: begin
                  for (int k = 0; k < 3; k++) begin
                     tb_in[k] = 33'($signed(nx_ff[k])) - 33'($signed(rd_pt[k]));
                  end
               end
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff[2:0] == 3'd6) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (e_zero || ta_zero || tb_zero) begin
               state_in = S_NEXT;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  nmag_in[0][k] = mag33(e_v[k]);
                  nmag_in[1][k] = mag33(ta_ff[k]);
                  nmag_in[2][k] = mag33(tb_ff[k]);
                  nsgn_in[0][k] = e_v[k][32];
                  nsgn_in[1][k] = ta_ff[k][32];
                  nsgn_in[2][k] = tb_ff[k][32];
               end
               for (int v = 0; v < 3; v++) begin
                  nsh_in[v] = '0;
               end
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            for (int v = 0; v < 3; v++) begin
               if (n_hi[v]) begin
                  for (int k = 0; k < 3; k++) begin
                     nmag_in[v][k] = nmag_ff[v][k] >> 1;
                  end
                  nsh_in[v] = nsh_ff[v] + 6'sd1;
               end else if (n_lo[v]) begin
                  for (int k = 0; k < 3; k++) begin
                     nmag_in[v][k] = nmag_ff[v][k] << 1;
                  end
                  nsh_in[v] = nsh_ff[v] - 6'sd1;
               end
            end
            if ((n_hi | n_lo) == 3'b000) begin
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            case (step_ff[3:0])
               4'd0:  begin mul_a = 43'(nv[1][1]); mul_b = nv[2][2]; end
               4'd1:  begin mul_a = 43'(nv[1][2]); mul_b = nv[2][1]; end
               4'd2:  begin mul_a = 43'(nv[1][2]); mul_b = nv[2][0]; end
               4'd3:  begin mul_a = 43'(nv[1][0]); mul_b = nv[2][2]; end
               4'd4:  begin mul_a = 43'(nv[1][0]); mul_b = nv[2][1]; end
               4'd5:  begin mul_a = 43'(nv[1][1]); mul_b = nv[2][0]; end
               4'd6:  begin mul_a = 43'(c_ff[0]); mul_b = nv[0][0]; end
               4'd7:  begin mul_a = 43'(c_ff[1]); mul_b = nv[0][1]; end
               4'd8:  begin mul_a = 43'(c_ff[2]); mul_b = nv[0][2]; end
               4'd9:  begin mul_a = 43'(nv[0][0]); mul_b = nv[0][0]; end
               4'd10: begin mul_a = 43'(nv[0][1]); mul_b = nv[0][1]; end
               4'd11: begin mul_a = 43'(nv[0][2]); mul_b = nv[0][2]; end
               default: ;
            endcase
            case (step_ff[3:0])
               4'd1:  c_in[0] = prod_ff[41:0];
               4'd2:  c_in[0] = c_ff[0] - prod_ff[41:0];
               4'd3:  c_in[1] = prod_ff[41:0];
               4'd4:  c_in[1] = c_ff[1] - prod_ff[41:0];
               4'd5:  c_in[2] = prod_ff[41:0];
               4'd6:  c_in[2] = c_ff[2] - prod_ff[41:0];
               4'd7:  num_in = prod_ff;
               4'd8:  num_in = num_ff + prod_ff;
               4'd9:  num_in = num_ff + prod_ff;
               4'd10: sq_in = prod_ff[42:0];
               4'd11: sq_in = sq_ff + prod_ff[42:0];
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff[3:0] == 4'd12) begin
               sx_in   = sq_ff + prod_ff[42:0];
               sr_in   = '0;
               sbit_in = 43'd1 << 42;
               nneg_in = num_ff[63];
               rem_in  = num_mag;
               t_in    = 8'(nsh_ff[1]) + 8'(nsh_ff[2]) - (8'(nsh_ff[0]) <<< 1)
                         + 8'(ACC_FRAC - 2);
               state_in = (num_ff == '0) ? S_NEXT : S_SQRT;
            end
         end
         S_SQRT: begin
            if (sx_ff >= sq_tmp) begin
               sx_in = sx_ff - sq_tmp;
               sr_in = (sr_ff >> 1) + sbit_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff == 43'd1) begin
               step_in  = '0;
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            case (step_ff[1:0])
               2'd0: begin
                  mul_a = $signed({22'd0, d_root});
                  mul_b = $signed({1'b0, d_root});
               end
               2'd1: begin
                  mul_a = $signed({1'b0, prod_ff[41:0]});
                  mul_b = $signed({1'b0, d_root});
               end
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff[1:0] == 2'd2) begin
               den_in   = prod_ff[62:0];
               dv_in    = {prod_ff[62:0], 5'd0};
               q_in     = '0;
               step_in  = '0;
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            ge = (rem_ext >= dv_ff);
            if (ge) begin
               rem_in = rem_ff - dv_ff[63:0];
            end
            q_in    = {q_ff[62:0], ge};
            dv_in   = dv_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff[2:0] == 3'd5) begin
               if (t_ff[7]) begin
                  state_in = S_ACC;
               end else begin
                  step_in  = t_ff[6:0];
                  state_in = S_DIVF;
               end
            end
         end
         S_DIVF: begin
            if (step_ff == '0) begin
               state_in = S_ACC;
            end else if (q_ff[63] || q_ff[62]) begin
               q_in     = 64'h7FFF_FFFF_FFFF_FFFF;
               ovf_in   = 1'b1;
               state_in = S_ACC;
            end else begin
               ge = (rem2 >= {2'd0, den_ff});
               rem_in  = ge ? 64'(rem2 - {2'd0, den_ff}) : rem2[63:0];
               q_in    = {q_ff[62:0], ge};
               step_in = step_ff - 1'b1;
            end
         end
         S_ACC: begin
            if ((sum_ff[63] == term[63]) && (sum_raw[63] != sum_ff[63])) begin
               sum_in = term[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_raw;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  state_in = S_FIN0;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_PAIR;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_PAIR;
            end
         end
         S_FIN0: begin
            fmul_a   = ps_mag[31:0];
            state_in = S_FIN1;
         end
         S_FIN1: begin
            fmul_a   = ps_mag[63:32];
            facc_in  = fprod_ff[63:32];
            state_in = S_OUT;
         end
         S_OUT: begin
            fmul_a = ps_mag[63:32];
            if (!rsp_valid_ff || rsp_ready) begin
               out_load    = 1'b1;
               rsp_data_in = '{link_value: res_val, overflow: ovf_ff || res_sat};
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         na_ff        <= '0;
         nj_ff        <= '0;
         other_b_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         na_ff        <= na_in;
         nj_ff        <= nj_in;
         other_b_ff   <= other_b_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      nx_ff       <= nx_in;
      ta_ff       <= ta_in;
      tb_ff       <= tb_in;
      nmag_ff     <= nmag_in;
      nsgn_ff     <= nsgn_in;
      nsh_ff      <= nsh_in;
      c_ff        <= c_in;
      num_ff      <= num_in;
      sq_ff       <= sq_in;
      prod_ff     <= prod_in;
      sx_ff       <= sx_in;
      sr_ff       <= sr_in;
      sbit_ff     <= sbit_in;
      t_ff        <= t_in;
      nneg_ff     <= nneg_in;
      den_ff      <= den_in;
      dv_ff       <= dv_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      fprod_ff    <= fprod_in;
      facc_ff     <= facc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### design/gli_curve_mem.sv
// ============================================================================
// gli_curve_mem
// Point store for one curve: one write port and one registered read port.
// ============================================================================
module gli_curve_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  gli_pkg::point_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output gli_pkg::point_type  rd_data
);
   import gli_pkg::*;

   point_type mem [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/gli_checker.sv
// ============================================================================
// gli_port_checks
// Port-level checks on the linking integral engine, bound to its top level.
// ============================================================================
module gli_port_checks (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input gli_pkg::req_type           req_data,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input gli_pkg::rsp_type           rsp_data,
   input logic                       pready
);
   import gli_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_COMPUTE |=> !req_ready)
      else $error("block ready in the cycle after a compute item");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result item appeared without a compute in progress");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind gauss_linking_integral gli_port_checks u_gli_port_checks (.*);

### verif/gli_checker.sv
// ============================================================================
// gli_checker
// Watches the item, result and register ports of the linking integral engine.
// It keeps its own copy of the point stores and registers and works out the
// link value and overflow flag of every compute command. It then compares each
// result with the oldest outstanding expectation.
// ============================================================================
module gli_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  gli_pkg::req_type           req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  gli_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [gli_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   input  logic                       pready,
   output int                         errors,
   output int                         pending
);
   import gli_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } vec_type;

   localparam int NPTS = 1024;
   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

   logic signed [31:0] a_x[NPTS], a_y[NPTS], a_z[NPTS];
   logic signed [31:0] b_x[NPTS], b_y[NPTS], b_z[NPTS];
   logic               cur_mode;
   logic [10:0]        cur_count_a, cur_count_b;
   rsp_type            link_q[$];

   assign pending = link_q.size();

   function automatic longint unsigned magn(input longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   function automatic vec_type norm_vec(input vec_type v, output int s);
      longint unsigned m, w;
      longint unsigned c[3];
      longint sv[3];
      int bl;
      vec_type o;
      sv[0] = v.x; sv[1] = v.y; sv[2] = v.z;
      m = 0;
      for (int k = 0; k < 3; k++) begin
         c[k] = magn(sv[k]);
         if (c[k] > m) m = c[k];
      end
      bl = 0;
      w = m;
      while (w != 0) begin
         bl++;
         w = w >> 1;
      end
      s = bl - NORM_BITS;
      for (int k = 0; k < 3; k++) begin
         c[k] = s > 0 ? c[k] >> s : c[k] << (-s);
         sv[k] = sv[k] < 0 ? -longint'(c[k]) : longint'(c[k]);
      end
      o.x = sv[0]; o.y = sv[1]; o.z = sv[2];
      return o;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint pair_term(input vec_type e, input vec_type ta,
                                        input vec_type tb, inout bit ovf);
      vec_type en, an, bn;
      int se, sa, sb, t;
      longint cx, cy, cz, num;
      longint unsigned d, den, m, q, r;
      bit sat;
      if (e == '0 || ta == '0 || tb == '0) return 0;
      en = norm_vec(e, se);
      an = norm_vec(ta, sa);
      bn = norm_vec(tb, sb);
      cx = an.y * bn.z - an.z * bn.y;
      cy = an.z * bn.x - an.x * bn.z;
      cz = an.x * bn.y - an.y * bn.x;
      num = en.x * cx + en.y * cy + en.z * cz;
      if (num == 0) return 0;
      d = int_sqrt(en.x * en.x + en.y * en.y + en.z * en.z);
      den = d * d * d;
      t = sa + sb - 2 * se - 2 + ACC_FRAC;
      m = magn(num);
      if (t >= 0) begin
         q = m / den;
         r = m % den;
         sat = 0;
         for (int k = 0; k < t && !sat; k++) begin
            if (q >= (64'd1 << 62)) begin
               sat = 1;
               ovf = 1;
               q = I64_MAX;
            end else begin
               q = q << 1;
               r = r << 1;
               if (r >= den) begin
                  r = r - den;
                  q = q | 64'd1;
               end
            end
         end
      end else begin
         q = (-t >= 64) ? 64'd0 : (m / den) >> (-t);
      end
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic vec_type point_at(input bit from_b, input int i);
      vec_type p;
      if (from_b) begin
         p.x = b_x[i]; p.y = b_y[i]; p.z = b_z[i];
      end else begin
         p.x = a_x[i]; p.y = a_y[i]; p.z = a_z[i];
      end
      return p;
   endfunction

   function automatic vec_type tangent_at(input bit from_b, input int n, input int i);
      vec_type nx, pv, t;
      nx = point_at(from_b, (i + 1) % n);
      pv = point_at(from_b, (i + n - 1) % n);
      t.x = nx.x - pv.x; t.y = nx.y - pv.y; t.z = nx.z - pv.z;
      return t;
   endfunction

   function automatic rsp_type linking_value();
      int na, nj;
      bit from_b, ovf;
      longint acc, term, sum;
      longint unsigned m, hi, lo, res;
      vec_type pa, ta, pb, tb, e;
      rsp_type o;
      na = cur_count_a > NPTS ? NPTS : cur_count_a;
      nj = cur_mode ? na : (cur_count_b > NPTS ? NPTS : cur_count_b);
      from_b = !cur_mode;
      ovf = 0;
      acc = 0;
      for (int i = 0; i < na; i++) begin
         pa = point_at(0, i);
         ta = tangent_at(0, na, i);
         for (int j = 0; j < nj; j++) begin
            if (!(cur_mode && i == j)) begin
               pb = point_at(from_b, j);
               tb = tangent_at(from_b, nj, j);
               e.x = pa.x - pb.x; e.y = pa.y - pb.y; e.z = pa.z - pb.z;
               term = pair_term(e, ta, tb, ovf);
               sum = acc + term;
               if (term > 0 && sum < acc) begin
                  ovf = 1;
                  acc = I64_MAX;
               end else if (term < 0 && sum > acc) begin
                  ovf = 1;
                  acc = I64_MIN;
               end else begin
                  acc = sum;
               end
            end
         end
      end
      m = magn(acc);
      hi = m >> 32;
      lo = m & 64'hFFFF_FFFF;
      res = (hi * INV_4PI_Q32 + ((lo * INV_4PI_Q32) >> 32)) >> RESULT_SHIFT;
      if (acc < 0) begin
         if (res > 64'h8000_0000) begin
            res = 64'h8000_0000;
            ovf = 1;
         end
         res = 64'd0 - res;
      end else if (res > 64'h7FFF_FFFF) begin
         res = 64'h7FFF_FFFF;
         ovf = 1;
      end
      o.link_value = res[31:0];
      o.overflow = ovf;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         link_q.delete();
         cur_mode <= 1'b0;
         cur_count_a <= 11'd1;
         cur_count_b <= 11'd1;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_type'(paddr[3:2]))
               REG_MODE:    cur_mode <= pwdata[0];
               REG_COUNT_A: cur_count_a <= pwdata[10:0];
               REG_COUNT_B: cur_count_b <= pwdata[10:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.command)
               CMD_WRITE_A: begin
                  a_x[req_data.index] = req_data.px;
                  a_y[req_data.index] = req_data.py;
                  a_z[req_data.index] = req_data.pz;
               end
               CMD_WRITE_B: begin
                  b_x[req_data.index] = req_data.px;
                  b_y[req_data.index] = req_data.py;
                  b_z[req_data.index] = req_data.pz;
               end
               CMD_COMPUTE: link_q.push_back(linking_value());
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (link_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: link_value %h overflow %b",
                           rsp_data.link_value, rsp_data.overflow);
            end else begin
               want = link_q.pop_front();
               if (want.link_value !== rsp_data.link_value
                   || want.overflow !== rsp_data.overflow) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected link_value %h overflow %b, got %h %b",
                              want.link_value, want.overflow,
                              rsp_data.link_value, rsp_data.overflow);
               end
            end
         end
      end
   end

   initial errors = 0;

endmodule

### verif/tb.sv
// ============================================================================
// tb
// Stimulus for the linking integral engine.
// Loads small closed curves with assorted coordinates, sets the mode and point
// counts between phases and issues compute commands, with bursty items and a
// stalling result side. The checker judges every result.
// ============================================================================
module tb;
   import gli_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_NOP = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;
   int                errors, pending;
   int                burst_left = 0;
   int                items = 0;
   int                stall_kind = 0;
   int                stall_left = 0;
   bit                a_ok[1024], b_ok[1024];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gauss_linking_integral u_top (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   gli_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
   );

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic logic [31:0] coord(input int style);
      logic [31:0] picks[5];
      picks = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         2: return picks[$urandom_range(0, 4)];
         default: return ($urandom_range(0, 3) << 16);
      endcase
   endfunction

   task automatic send(input logic [1:0] cmd, input int idx, input int style);
      req_type d;
      int gap;
      d.command = cmd;
      d.index = 10'(idx);
      d.px = coord(style);
      d.py = coord(style);
      d.pz = coord(style);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_WRITE_A) a_ok[idx] = 1;
      if (cmd == CMD_WRITE_B) b_ok[idx] = 1;
      if (cmd != CMD_NOP) items++;
   endtask

   task automatic noise();
      case ($urandom_range(0, 2))
         0: send(CMD_NOP, $urandom_range(0, 1023), 0);
         1: send(CMD_WRITE_A, $urandom_range(0, 1023), 0);
         default: send(CMD_WRITE_B, $urandom_range(0, 1023), 0);
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input reg_type r, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_curve(input logic [1:0] cmd, input int n, input int style,
                             input bit reuse);
      int off, idx;
      off = $urandom_range(0, 1023);
      for (int i = 0; i < n; i++) begin
         idx = (i + off) % n;
         if (!reuse || (cmd == CMD_WRITE_A ? !a_ok[idx] : !b_ok[idx]))
            send(cmd, idx, style < 0 ? $urandom_range(0, 3) : style);
         if ($urandom_range(0, 9) == 0) noise();
      end
   endtask

   task automatic run_phase(input bit m, input int ca, input int cb, input int style,
                            input bit reuse);
      int na, nb, n_comp;
      na = ca > 1024 ? 1024 : ca;
      nb = cb > 1024 ? 1024 : cb;
      wait_idle();
      csr_write(REG_MODE, {31'd0, m});
      csr_write(REG_COUNT_A, ca);
      csr_write(REG_COUNT_B, cb);
      load_curve(CMD_WRITE_A, na, style, reuse);
      if (!m && na > 0) load_curve(CMD_WRITE_B, nb, style, reuse);
      n_comp = $urandom_range(1, 2);
      for (int k = 0; k < n_comp; k++) begin
         send(CMD_COMPUTE, $urandom_range(0, 1023), 0);
         if (na > 0) send(CMD_WRITE_A, $urandom_range(0, na - 1), $urandom_range(0, 3));
      end
   endtask

   initial begin
      int ca, cb;
      bit m;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_phase(1, 3, 1024, 2, 0);
      run_phase(0, 1, 1, 0, 0);
      run_phase(0, 0, 2047, 0, 0);
      run_phase(1, 4, 5, 3, 0);
      run_phase(0, 2, 3, 1, 0);
      while (items < 500) begin
         m = 1'($urandom_range(0, 1));
         ca = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         cb = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         if (m && $urandom_range(0, 3) == 0) cb = $urandom_range(0, 2047);
         run_phase(m, ca, cb, $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : -1,
                   $urandom_range(0, 3) == 0);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
design/gli_pkg.sv
design/gli_curve_mem.sv
design/gauss_linking_integral.sv
design/gli_checker.sv
verif/gli_checker.sv
verif/tb.sv
